// ===== sv/eorr_pkg.sv =====
package eorr_pkg;

   localparam logic [31:0] MAX_READ_BYTES = 32'd16777216;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_TABLE_FULL   = 3'd1,
      STATUS_EMPTY        = 3'd2,
      STATUS_DEST_RANGE   = 3'd3,
      STATUS_SOURCE_RANGE = 3'd4,
      STATUS_READ_RANGE   = 3'd5,
      STATUS_READ_LARGE   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_OVERLAY  = 2'd0,
      KIND_ORIGINAL = 2'd1,
      KIND_ZERO     = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic CSR_VIRT_SIZE     = 1'b0;
   localparam logic CSR_ORIGINAL_SIZE = 1'b1;

   typedef struct packed {
      logic        is_read;
      logic        single;
      status_type  status;
      logic [63:0] start;
      logic [63:0] stop;
      logic [7:0]  source;
      logic [63:0] delta;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      kind_type    kind;
      logic [7:0]  segment_source;
      logic [63:0] segment_offset;
      logic [24:0] buffer_offset;
      logic [24:0] segment_length;
      logic        last;
   } res_type;

endpackage

// ===== sv/eorr_fifo.sv =====
module eorr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== sv/eorr_front.sv =====
module eorr_front import eorr_pkg::*; (
   input  logic        req_cmd,
   input  logic [63:0] req_address,
   input  logic [31:0] req_length,
   input  logic [7:0]  req_source_id,
   input  logic [63:0] req_source_offset,
   input  logic [63:0] req_source_size,
   input  logic [63:0] virt_size,
   output cmd_type     entry
);
   logic [63:0] len64;
   logic        len_zero, range_bad, source_bad, too_large;

   assign len64      = {32'd0, req_length};
   assign len_zero   = (req_length == '0);
   assign range_bad  = (req_address > virt_size) || (len64 > virt_size - req_address);
   assign source_bad = (req_source_offset > req_source_size) ||
                       (len64 > req_source_size - req_source_offset);
   assign too_large  = (req_length > MAX_READ_BYTES);

   always_comb begin
      entry.is_read = (req_cmd == CMD_READ);
      entry.start   = req_address;
      entry.stop    = req_address + len64;
      entry.source  = req_source_id;
      entry.delta   = req_source_offset - req_address;
      if (req_cmd == CMD_READ) begin
         entry.single = range_bad || len_zero || too_large;
         priority if (range_bad) begin
            entry.status = STATUS_READ_RANGE;
         end else if (len_zero) begin
            entry.status = STATUS_OK;
         end else if (too_large) begin
            entry.status = STATUS_READ_LARGE;
         end else begin
            entry.status = STATUS_OK;
         end
      end else begin
         entry.single = 1'b1;
         priority if (len_zero) begin
            entry.status = STATUS_EMPTY;
         end else if (range_bad) begin
            entry.status = STATUS_DEST_RANGE;
         end else if (source_bad) begin
            entry.status = STATUS_SOURCE_RANGE;
         end else begin
            entry.status = STATUS_OK;
         end
      end
   end
endmodule

// ===== sv/eorr_back.sv =====
module eorr_back import eorr_pkg::*; #(
   parameter int MAX_EXTENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] original_size,
   input  logic        q_empty,
   input  cmd_type     q_entry,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output res_type     rsp
);
   localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CW = $clog2(MAX_EXTENTS + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_PICK  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   logic [63:0] ext_base_ff   [MAX_EXTENTS];
   logic [63:0] ext_stop_ff   [MAX_EXTENTS];
   logic [7:0]  ext_source_ff [MAX_EXTENTS];
   logic [63:0] ext_delta_ff  [MAX_EXTENTS];

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [IW-1:0] win_idx_ff, win_idx_in, rd_idx;
   logic        win_ff, win_in;
   logic [63:0] cur_ff, cur_in, start_ff, start_in, stop_ff, stop_in, next_ff, next_in;
   logic [5:0]  seg_ff, seg_in;
   res_type     res_ff, res_in;
   logic        valid_ff, valid_in, out_free, wr_en;
   logic [63:0] es, ee, mid;
   logic [CW-1:0] k;

   assign out_free  = !valid_ff || rsp_pop;
   assign rsp_empty = !valid_ff;
   assign rsp       = res_ff;
   assign k         = idx_ff - 1'b1;
   assign rd_idx    = state_ff == ST_PICK ? k[IW-1:0] : idx_ff[IW-1:0];
   assign es        = ext_base_ff[rd_idx];
   assign ee        = ext_stop_ff[rd_idx];
   assign mid       = (es > cur_ff && es < next_ff) ? es : next_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      win_idx_in = win_idx_ff;
      win_in     = win_ff;
      cur_in     = cur_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      next_in    = next_ff;
      seg_in     = seg_ff;
      res_in     = res_ff;
      valid_in   = valid_ff && !rsp_pop;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_entry.single) begin
                  if (out_free) begin
                     q_pop                 = 1'b1;
                     valid_in              = 1'b1;
                     res_in                = '0;
                     res_in.status         = q_entry.status;
                     res_in.kind           = KIND_NONE;
                     res_in.last           = 1'b1;
                     if (!q_entry.is_read) begin
                        if (count_ff == CW'(MAX_EXTENTS)) begin
                           res_in.status = STATUS_TABLE_FULL;
                        end else if (q_entry.status == STATUS_OK) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
               end else begin
                  q_pop    = 1'b1;
                  start_in = q_entry.start;
                  cur_in   = q_entry.start;
                  stop_in  = q_entry.stop;
                  seg_in   = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            next_in  = (original_size > cur_ff && original_size < stop_ff) ?
                       original_size : stop_ff;
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_PICK;
            end else begin
               next_in = (ee > cur_ff && ee < mid) ? ee : mid;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_PICK: begin
            if (idx_ff == '0) begin
               win_in   = 1'b0;
               state_in = ST_EMIT;
            end else if (es <= cur_ff && ee >= next_ff) begin
               win_in     = 1'b1;
               win_idx_in = k[IW-1:0];
               state_in   = ST_EMIT;
            end else begin
               idx_in = k;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               valid_in              = 1'b1;
               res_in.status         = STATUS_OK;
               res_in.buffer_offset  = 25'(cur_ff - start_ff);
               res_in.segment_length = 25'(next_ff - cur_ff);
               res_in.last           = (next_ff >= stop_ff);
               if (win_ff) begin
                  res_in.kind           = KIND_OVERLAY;
                  res_in.segment_source = ext_source_ff[win_idx_ff];
                  res_in.segment_offset = ext_delta_ff[win_idx_ff] + cur_ff;
               end else if (cur_ff < original_size) begin
                  res_in.kind           = KIND_ORIGINAL;
                  res_in.segment_source = '0;
                  res_in.segment_offset = cur_ff;
               end else begin
                  res_in.kind           = KIND_ZERO;
                  res_in.segment_source = '0;
                  res_in.segment_offset = '0;
               end
               cur_in = next_ff;
               seg_in = seg_ff + 1'b1;
               state_in = (next_ff >= stop_ff || seg_ff == 6'd63) ? ST_IDLE : ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      idx_ff     <= idx_in;
      win_idx_ff <= win_idx_in;
      win_ff     <= win_in;
      cur_ff     <= cur_in;
      start_ff   <= start_in;
      stop_ff    <= stop_in;
      next_ff    <= next_in;
      seg_ff     <= seg_in;
      res_ff     <= res_in;
      if (wr_en) begin
         ext_base_ff[count_ff[IW-1:0]]   <= q_entry.start;
         ext_stop_ff[count_ff[IW-1:0]]   <= q_entry.stop;
         ext_source_ff[count_ff[IW-1:0]] <= q_entry.source;
         ext_delta_ff[count_ff[IW-1:0]]  <= q_entry.delta;
      end
   end
endmodule

// ===== sv/extent_overlay_read_resolver_unit.sv =====
// An append request's single response passes through the request queue and the result register.
// A read request gives one response per segment, at most 64, or a single response when it is
// rejected or empty; each segment is found by a forward walk over the extent table for the next
// boundary and a backward walk for the newest covering extent, which stops at a hit.
// Synchronous active-high reset empties the extent table, the queues and the sizes.
module extent_overlay_read_resolver_unit import eorr_pkg::*; #(
   parameter int MAX_EXTENTS = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [63:0] req_address,
   input  logic [31:0] req_length,
   input  logic [7:0]  req_source_id,
   input  logic [63:0] req_source_offset,
   input  logic [63:0] req_source_size,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_segment_source,
   output logic [63:0] rsp_segment_offset,
   output logic [24:0] rsp_buffer_offset,
   output logic [24:0] rsp_segment_length,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] virt_size_ff, original_size_ff;
   cmd_type     front_entry, q_entry;
   logic        q_empty, q_pop;
   res_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         virt_size_ff     <= '0;
         original_size_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_VIRT_SIZE) begin
            virt_size_ff <= csr_data;
         end
         if (csr_index == CSR_ORIGINAL_SIZE) begin
            original_size_ff <= csr_data;
         end
      end
   end

   eorr_front u_front (
      .req_cmd           (req_cmd),
      .req_address       (req_address),
      .req_length        (req_length),
      .req_source_id     (req_source_id),
      .req_source_offset (req_source_offset),
      .req_source_size   (req_source_size),
      .virt_size         (virt_size_ff),
      .entry             (front_entry)
   );

   eorr_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .full      (full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_entry)
   );

   eorr_back #(
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .original_size (original_size_ff),
      .q_empty       (q_empty),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp           (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_kind           = rsp.kind;
   assign rsp_segment_source = rsp.segment_source;
   assign rsp_segment_offset = rsp.segment_offset;
   assign rsp_buffer_offset  = rsp.buffer_offset;
   assign rsp_segment_length = rsp.segment_length;
   assign rsp_last           = rsp.last;
endmodule

// ===== tb/extent_overlay_read_resolver_unit_tb.sv =====
module extent_overlay_read_resolver_unit_tb import eorr_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 80;

   class extent_scoreboard;
      logic [63:0] virt_size;
      logic [63:0] original_size;
      int          extent_count;
      logic [63:0] ext_base[TABLE_DEPTH];
      logic [31:0] ext_length[TABLE_DEPTH];
      logic [7:0]  ext_source[TABLE_DEPTH];
      logic [63:0] ext_source_start[TABLE_DEPTH];
      res_type     pending_segments[$];
      int          errors;

      function new();
         virt_size = '0;
         original_size = '0;
         extent_count = 0;
         errors = 0;
      endfunction

      function void expect_single(status_type status);
         res_type r;
         r = '0;
         r.status = status;
         r.kind = KIND_NONE;
         r.last = 1'b1;
         pending_segments.insert(pending_segments.size(), r);
      endfunction

      function void note_request(logic cmd, logic [63:0] addr, logic [31:0] len,
                                 logic [7:0] sid, logic [63:0] soff, logic [63:0] ssize);
         logic [63:0] stop;
         logic [63:0] cur;
         logic [63:0] nxt;
         logic [63:0] es;
         logic [63:0] ee;
         int          win;
         int          n;
         res_type     r;
         if (cmd == CMD_APPEND) begin
            if (extent_count >= TABLE_DEPTH) begin
               expect_single(STATUS_TABLE_FULL);
            end else if (len == 0) begin
               expect_single(STATUS_EMPTY);
            end else if (addr > virt_size || {32'd0, len} > virt_size - addr) begin
               expect_single(STATUS_DEST_RANGE);
            end else if (soff > ssize || {32'd0, len} > ssize - soff) begin
               expect_single(STATUS_SOURCE_RANGE);
            end else begin
               ext_base[extent_count] = addr;
               ext_length[extent_count] = len;
               ext_source[extent_count] = sid;
               ext_source_start[extent_count] = soff;
               extent_count++;
               expect_single(STATUS_OK);
            end
            return;
         end
         if (addr > virt_size || {32'd0, len} > virt_size - addr) begin
            expect_single(STATUS_READ_RANGE);
            return;
         end
         if (len == 0) begin
            expect_single(STATUS_OK);
            return;
         end
         if (len > MAX_READ_BYTES) begin
            expect_single(STATUS_READ_LARGE);
            return;
         end
         stop = addr + len;
         cur = addr;
         n = 0;
         while (cur < stop && n < 64) begin
            nxt = stop;
            win = -1;
            if (original_size > cur && original_size < nxt) nxt = original_size;
            for (int i = 0; i < extent_count; i++) begin
               es = ext_base[i];
               ee = es + ext_length[i];
               if (es > cur && es < nxt) nxt = es;
               if (ee > cur && ee < nxt) nxt = ee;
            end
            for (int i = extent_count - 1; i >= 0; i--) begin
               es = ext_base[i];
               ee = es + ext_length[i];
               if (es <= cur && ee >= nxt) begin
                  win = i;
                  break;
               end
            end
            r = '0;
            r.status = STATUS_OK;
            r.buffer_offset = 25'(cur - addr);
            r.segment_length = 25'(nxt - cur);
            r.last = (nxt >= stop);
            if (win >= 0) begin
               r.kind = KIND_OVERLAY;
               r.segment_source = ext_source[win];
               r.segment_offset = ext_source_start[win] + (cur - ext_base[win]);
            end else if (cur < original_size) begin
               r.kind = KIND_ORIGINAL;
               r.segment_offset = cur;
            end else begin
               r.kind = KIND_ZERO;
            end
            pending_segments.insert(pending_segments.size(), r);
            n++;
            cur = nxt;
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("Mismatch on %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_response(res_type got);
         res_type want;
         if (pending_segments.size() == 0) begin
            report("unexpected response", 64'(got.status), 64'd0);
            return;
         end
         want = pending_segments.pop_front();
         if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
         if (got.kind !== want.kind) report("kind", 64'(got.kind), 64'(want.kind));
         if (got.segment_source !== want.segment_source)
            report("segment_source", 64'(got.segment_source), 64'(want.segment_source));
         if (got.segment_offset !== want.segment_offset)
            report("segment_offset", got.segment_offset, want.segment_offset);
         if (got.buffer_offset !== want.buffer_offset)
            report("buffer_offset", 64'(got.buffer_offset), 64'(want.buffer_offset));
         if (got.segment_length !== want.segment_length)
            report("segment_length", 64'(got.segment_length), 64'(want.segment_length));
         if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_cmd = 1'b0;
   logic [63:0] req_address = '0;
   logic [31:0] req_length = '0;
   logic [7:0]  req_source_id = '0;
   logic [63:0] req_source_offset = '0;
   logic [63:0] req_source_size = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_segment_source;
   logic [63:0] rsp_segment_offset;
   logic [24:0] rsp_buffer_offset;
   logic [24:0] rsp_segment_length;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_VIRT_SIZE;
   logic [63:0] csr_data = '0;

   extent_scoreboard sb = new();
   bit               quiet = 1'b0;
   int               pop_stall = 0;
   int               cycle_count = 0;

   extent_overlay_read_resolver_unit i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_cmd(req_cmd), .req_address(req_address), .req_length(req_length),
      .req_source_id(req_source_id), .req_source_offset(req_source_offset),
      .req_source_size(req_source_size), .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_kind(rsp_kind),
      .rsp_segment_source(rsp_segment_source), .rsp_segment_offset(rsp_segment_offset),
      .rsp_buffer_offset(rsp_buffer_offset), .rsp_segment_length(rsp_segment_length),
      .rsp_last(rsp_last), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      res_type got;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && pop && !empty) begin
         got.status = status_type'(rsp_status);
         got.kind = kind_type'(rsp_kind);
         got.segment_source = rsp_segment_source;
         got.segment_offset = rsp_segment_offset;
         got.buffer_offset = rsp_buffer_offset;
         got.segment_length = rsp_segment_length;
         got.last = rsp_last;
         sb.check_response(got);
      end
      if (pop_stall > 0) begin
         pop_stall--;
         pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         pop_stall = $urandom_range(0, 5);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(logic cmd, logic [63:0] addr, logic [31:0] len,
                       logic [7:0] sid, logic [63:0] soff, logic [63:0] ssize);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      push <= 1'b1;
      req_cmd <= cmd;
      req_address <= addr;
      req_length <= len;
      req_source_id <= sid;
      req_source_offset <= soff;
      req_source_size <= ssize;
      do @(posedge clock); while (full);
      sb.note_request(cmd, addr, len, sid, soff, ssize);
   endtask

   task automatic set_sizes(logic [63:0] vsize, logic [63:0] osize);
      push <= 1'b0;
      @(posedge clock);
      while (sb.pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_VIRT_SIZE;
      csr_data <= vsize;
      @(posedge clock);
      csr_index <= CSR_ORIGINAL_SIZE;
      csr_data <= osize;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.virt_size = vsize;
      sb.original_size = osize;
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         send(1'($urandom_range(0, 1)), rand64(), $urandom, 8'($urandom_range(0, 255)),
              rand64(), rand64());
      end else if (pick <= 2) begin
         send(CMD_APPEND, 64'($urandom_range(0, 8191)), 32'($urandom_range(1, 2048)),
              8'($urandom_range(0, 255)), rand64() >> $urandom_range(0, 63),
              64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3)));
      end else begin
         send(CMD_READ, 64'($urandom_range(0, 8191)), 32'($urandom_range(1, 3000)),
              8'd0, 64'd0, 64'd0);
      end
   endtask

   initial begin
      logic [63:0] all_ones;
      all_ones = 64'hFFFF_FFFF_FFFF_FFFF;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_sizes(64'd0, 64'd0);
      send(CMD_APPEND, 64'd0, 32'd1, 8'd1, 64'd0, 64'd1);
      send(CMD_APPEND, 64'd0, 32'd0, 8'd1, 64'd0, 64'd1);
      send(CMD_READ, 64'd0, 32'd0, 8'd0, 64'd0, 64'd0);
      send(CMD_READ, 64'd1, 32'd0, 8'd0, 64'd0, 64'd0);
      send(CMD_READ, all_ones, 32'hFFFF_FFFF, 8'hFF, all_ones, all_ones);

      set_sizes(all_ones, 64'd4096);
      send(CMD_APPEND, all_ones - 64'hFFFF_FFFE, 32'hFFFF_FFFF, 8'hFF, 64'd0, all_ones);
      send(CMD_APPEND, 64'd100, 32'd10, 8'h5A, all_ones, all_ones);
      send(CMD_APPEND, 64'd100, 32'd10, 8'h5A, 64'd0, 64'd9);
      send(CMD_APPEND, 64'd2000, 32'd4000, 8'h80, 64'h1234_5678_0000, all_ones);
      send(CMD_READ, 64'd0, 32'd16777216, 8'd0, 64'd0, 64'd0);
      send(CMD_READ, 64'd0, 32'd16777217, 8'd0, 64'd0, 64'd0);
      send(CMD_READ, all_ones - 64'd200, 32'd100, 8'd0, 64'd0, 64'd0);
      send(CMD_READ, all_ones, 32'd1, 8'd0, 64'd0, 64'd0);
      send(CMD_READ, 64'd1990, 32'd3000, 8'd0, 64'd0, 64'd0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_sizes(64'd8192, 64'($urandom_range(1, 8191)));
            1: set_sizes(all_ones, 64'd0);
            2: set_sizes(64'd8192, all_ones);
            default: set_sizes(all_ones, 64'($urandom_range(0, 8192)));
         endcase
         for (int k = 0; k < 85; k++) begin
            if (phase == 3 && k >= 50) quiet = 1'b1;
            random_request();
         end
      end

      push <= 1'b0;
      @(posedge clock);
      while (sb.pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
